### sv/kfq_pkg.sv
// Shared types and constants for the keyed frame queue.
package kfq_pkg;

  localparam int KEY_W = 64;
  localparam int HDL_W = 32;
  localparam int OCC_W = 7;

  typedef enum logic [2:0] {
    ST_APPENDED = 3'd0,
    ST_REPLACED = 3'd1,
    ST_DROPPED  = 3'd2,
    ST_HIT      = 3'd3,
    ST_FALLBACK = 3'd4,
    ST_EMPTY    = 3'd5
  } status_t;

  typedef enum logic {
    ACT_PUSH = 1'b0,
    ACT_POP  = 1'b1
  } action_t;

  typedef struct packed {
    action_t           action;
    logic [KEY_W-1:0]  surface_key;
    logic [HDL_W-1:0]  frame_handle;
  } in_t;

  typedef struct packed {
    status_t           status;
    logic [HDL_W-1:0]  out_handle;
    logic [KEY_W-1:0]  other_key;
    logic [OCC_W-1:0]  occupancy;
  } out_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [HDL_W-1:0]  handle;
  } entry_t;

endpackage

### sv/kfq_mem.sv
// Entry store: one write port, one read port, registered read data.
module kfq_mem #(
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  kfq_pkg::entry_t          wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output kfq_pkg::entry_t          rdata
);
  import kfq_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/kfq_ctrl.sv
// Sequencer: key search, in-place update, append and order-keeping compaction.
module kfq_ctrl #(
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  kfq_pkg::in_t             in_data,
  output logic                     res_valid,
  input  logic                     res_ready,
  output kfq_pkg::out_t            res,
  output logic                     mem_we,
  output logic [$clog2(DEPTH)-1:0] mem_waddr,
  output kfq_pkg::entry_t          mem_wdata,
  output logic                     mem_re,
  output logic [$clog2(DEPTH)-1:0] mem_raddr,
  input  kfq_pkg::entry_t          mem_rdata
);
  import kfq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_SHIFT, S_DONE} state_t;

  state_t          state_r;
  in_t             req_r;
  out_t            res_r;
  entry_t          oldest_r;
  logic [CW-1:0]   cnt_r;
  logic [CW-1:0]   rd_idx_r;
  logic            cmp_vld_r;
  logic [AW-1:0]   cmp_idx_r;
  logic            wr_pend_r;
  logic [AW-1:0]   wr_idx_r;

  logic [CW-1:0]   cnt_m1;
  logic [CW-1:0]   cnt_p1;
  logic [CW-1:0]   rd_m1;
  logic            full;
  logic            is_push;
  logic            cmp_hit;
  logic            cmp_last;
  logic            issue_s;
  logic            issue_sh;
  logic            sh_done;
  entry_t          oldest;
  entry_t          new_entry;

  always_comb begin
    cnt_m1    = cnt_r - CW'(1);
    cnt_p1    = cnt_r + CW'(1);
    rd_m1     = rd_idx_r - CW'(1);
    full      = (cnt_r == CW'(DEPTH));
    is_push   = (req_r.action == ACT_PUSH);
    cmp_hit   = cmp_vld_r && (mem_rdata.key == req_r.surface_key);
    cmp_last  = cmp_vld_r && (cmp_idx_r == cnt_m1[AW-1:0]);
    oldest    = (cmp_idx_r == '0) ? mem_rdata : oldest_r;
    issue_s   = (state_r == S_SEARCH) && (rd_idx_r < cnt_r) && !cmp_hit;
    issue_sh  = (state_r == S_SHIFT) && (rd_idx_r < cnt_r);
    sh_done   = (state_r == S_SHIFT) && !issue_sh && !wr_pend_r;
    new_entry = '{key: req_r.surface_key, handle: req_r.frame_handle};
    mem_re    = issue_s || issue_sh;
    mem_raddr = rd_idx_r[AW-1:0];
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = new_entry;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && (cnt_r == '0) && (in_data.action == ACT_PUSH)) begin
          mem_we    = 1'b1;
          mem_wdata = '{key: in_data.surface_key, handle: in_data.frame_handle};
        end
      end
      S_SEARCH: begin
        if (cmp_hit && is_push) begin
          mem_we    = 1'b1;
          mem_waddr = cmp_idx_r;
        end else if (!cmp_hit && cmp_last && is_push && !full) begin
          mem_we    = 1'b1;
          mem_waddr = cnt_r[AW-1:0];
        end
      end
      S_SHIFT: begin
        if (wr_pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = wr_idx_r;
          mem_wdata = mem_rdata;
        end else if (sh_done && is_push) begin
          mem_we    = 1'b1;
          mem_waddr = cnt_m1[AW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign in_stall  = (state_r != S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      cmp_vld_r <= 1'b0;
      wr_pend_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            req_r <= in_data;
            if (cnt_r == '0) begin
              res_r.out_handle <= '0;
              res_r.other_key  <= '0;
              if (in_data.action == ACT_POP) begin
                res_r.status    <= ST_EMPTY;
                res_r.occupancy <= '0;
              end else begin
                res_r.status    <= ST_APPENDED;
                res_r.occupancy <= OCC_W'(1);
                cnt_r           <= CW'(1);
              end
              state_r <= S_DONE;
            end else begin
              rd_idx_r  <= '0;
              cmp_vld_r <= 1'b0;
              state_r   <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          cmp_vld_r <= issue_s;
          cmp_idx_r <= rd_idx_r[AW-1:0];
          if (issue_s) begin
            rd_idx_r <= rd_idx_r + CW'(1);
          end
          if (cmp_vld_r && (cmp_idx_r == '0)) begin
            oldest_r <= mem_rdata;
          end
          if (cmp_hit) begin
            res_r.other_key <= '0;
            if (is_push) begin
              res_r.status     <= ST_REPLACED;
              res_r.out_handle <= '0;
              res_r.occupancy  <= OCC_W'(cnt_r);
              state_r          <= S_DONE;
            end else begin
              res_r.status     <= ST_HIT;
              res_r.out_handle <= mem_rdata.handle;
              rd_idx_r         <= CW'(cmp_idx_r) + CW'(1);
              wr_pend_r        <= 1'b0;
              state_r          <= S_SHIFT;
            end
          end else if (cmp_last) begin
            if (is_push && !full) begin
              res_r.status     <= ST_APPENDED;
              res_r.out_handle <= '0;
              res_r.other_key  <= '0;
              res_r.occupancy  <= OCC_W'(cnt_p1);
              cnt_r            <= cnt_p1;
              state_r          <= S_DONE;
            end else begin
              res_r.status     <= is_push ? ST_DROPPED : ST_FALLBACK;
              res_r.out_handle <= is_push ? '0 : oldest.handle;
              res_r.other_key  <= oldest.key;
              rd_idx_r         <= CW'(1);
              wr_pend_r        <= 1'b0;
              state_r          <= S_SHIFT;
            end
          end
        end
        S_SHIFT: begin
          if (issue_sh) begin
            rd_idx_r  <= rd_idx_r + CW'(1);
            wr_pend_r <= 1'b1;
            wr_idx_r  <= rd_m1[AW-1:0];
          end else begin
            wr_pend_r <= 1'b0;
          end
          if (sh_done) begin
            if (is_push) begin
              res_r.occupancy <= OCC_W'(cnt_r);
            end else begin
              res_r.occupancy <= OCC_W'(cnt_m1);
              cnt_r           <= cnt_m1;
            end
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_no_rw_same: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re && (mem_waddr == mem_raddr)))
    else $error("read and write of the same entry in one cycle");

  a_occ_match: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> (res_r.occupancy == OCC_W'(cnt_r)))
    else $error("reported occupancy differs from count");

  a_shift_idx: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SHIFT) && wr_pend_r) |-> (CW'(wr_idx_r) < cnt_r))
    else $error("compaction write beyond queued entries");

endmodule

### sv/keyed_frame_queue_drop_oldest.sv
// Sequence: on an empty queue the push or pop is answered without a search; otherwise
// a key search over the queued entries (one read of the entry memory per cycle) plus,
// on a pop or a drop, a compaction that closes the gap, then the output register.
// Requests are taken one at a time: in_stall stays high until the result is taken.
// Reset (synchronous, rst_n low): queue empty, no result pending.
module keyed_frame_queue_drop_oldest #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  kfq_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output kfq_pkg::out_t out_data
);
  import kfq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  logic          res_valid;
  logic          res_ready;
  out_t          res;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_rdata;
  logic          out_valid_r;
  out_t          out_data_r;

  kfq_ctrl #(.DEPTH(QUEUE_DEPTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  kfq_mem #(.DEPTH(QUEUE_DEPTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
      out_data_r  <= res;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
